### rtl/dual_shift_chain_refresher_defines.svh
// Assertion macros for the dual shift chain refresher checker.
// Used by dscr_checker.sv; no other dependencies.
`ifndef DUAL_SHIFT_CHAIN_REFRESHER_DEFINES_SVH
`define DUAL_SHIFT_CHAIN_REFRESHER_DEFINES_SVH

// Same-cycle implication, reset-qualified
`define DSCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dscr checker: same-cycle property failed");

// Next-cycle implication, reset-qualified
`define DSCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dscr checker: next-cycle property failed");

`endif

### rtl/dscr_pkg.sv
// Shared types and constants for the dual shift chain refresher.
// No dependencies; imported by every module of the block except dscr_ram.
package dscr_pkg;

  // Chain lengths and image address widths
  localparam int LongBits   = 104;
  localparam int SharedBits = 64;
  localparam int LongAw     = $clog2(LongBits);
  localparam int SharedAw   = $clog2(SharedBits);

  // Input word function codes
  typedef enum logic [2:0] {
    FUNC_TICK       = 3'd0,
    FUNC_WR_LONG    = 3'd1,
    FUNC_WR_BAR     = 3'd2,
    FUNC_WR_BUTTON  = 3'd3,
    FUNC_ALL_OFF    = 3'd4
  } func_e;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] pin_index;
    logic       pin_level;
  } in_t;

  typedef struct packed {
    logic long_clock;
    logic long_data;
    logic long_latch;
    logic shared_clock;
    logic bar_data;
    logic button_data;
    logic shared_latch;
    logic frame_restart;
  } out_t;

endpackage

### rtl/dual_shift_chain_refresher.sv
// Dual shift chain refresher: one input word per cycle while the output buffer
// is not full; each result word is registered into that buffer on acceptance.
// Bit images sit in two registered-read memories prefetched at the next
// chain position; a two-word output buffer absorbs output stalls until full.
// Reset (async, active low) sets every image bit to 1, all pins low and
// both sequences to their start; no clearing sweep is needed.
module dual_shift_chain_refresher (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dscr_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dscr_pkg::out_t out_word_o
);
  import dscr_pkg::*;

  logic       accept, full, tick, all_off;
  logic       long_we, bar_we, button_we, shared_we;
  logic [1:0] shared_wmask_data;
  logic [1:0] shared_rd;
  logic       long_rd;
  logic [6:0] long_pos, shared_pos;
  out_t       res;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the accepted word
  always_comb begin
    tick      = 1'b0;
    all_off   = 1'b0;
    long_we   = 1'b0;
    bar_we    = 1'b0;
    button_we = 1'b0;
    case (func_e'(in_word_i.func))
      FUNC_TICK:      tick      = accept;
      FUNC_WR_LONG:   long_we   = accept && ({1'b0, in_word_i.pin_index} < 8'(LongBits));
      FUNC_WR_BAR:    bar_we    = accept && ({1'b0, in_word_i.pin_index} < 8'(SharedBits));
      FUNC_WR_BUTTON: button_we = accept && ({1'b0, in_word_i.pin_index} < 8'(SharedBits));
      FUNC_ALL_OFF:   all_off   = accept;
      default: ;
    endcase
  end

  dscr_ram #(.Depth(LongBits), .Width(1)) u_long_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (long_we),
    .wmask_i (1'b1),
    .waddr_i (in_word_i.pin_index[LongAw-1:0]),
    .wdata_i (in_word_i.pin_level),
    .clear_i (all_off),
    .raddr_i (long_pos[LongAw-1:0]),
    .rdata_o (long_rd)
  );

  // Bar and button bits share one word: bar in lane 0, button in lane 1;
  // the write mask keeps the other lane.
  assign shared_we         = bar_we || button_we;
  assign shared_wmask_data = {button_we, bar_we};

  dscr_ram #(.Depth(SharedBits), .Width(2)) u_shared_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (shared_we),
    .wmask_i (shared_wmask_data),
    .waddr_i (in_word_i.pin_index[SharedAw-1:0]),
    .wdata_i ({2{in_word_i.pin_level}}),
    .clear_i (all_off),
    .raddr_i (shared_pos[SharedAw-1:0]),
    .rdata_o (shared_rd)
  );

  dscr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .long_rd_i    (long_rd),
    .shared_rd_i  (shared_rd),
    .long_pos_o   (long_pos),
    .shared_pos_o (shared_pos),
    .res_o        (res)
  );

  dscr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_word_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

### rtl/dscr_ram.sv
// Bit image store: synchronous memory, registered read, per-lane
// write mask and valid flops (unwritten lanes read as ones), write forwarding.
// Depends on nothing outside this file.
module dscr_ram #(
  parameter int Depth = 64,
  parameter int Width = 1,
  localparam int Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [Width-1:0] wmask_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             clear_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] vld_q [Depth];
  logic [Width-1:0] rdata_q;
  logic [Width-1:0] rvld_q;
  logic [Width-1:0] fwd;
  logic             rd_ok;

  assign rd_ok = (32'(raddr_i) < Depth);
  assign fwd   = (we_i && (waddr_i == raddr_i)) ? wmask_i : '0;

  // Store written lanes
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < Width; b++) begin
      if (we_i && wmask_i[b]) begin
        mem_q[waddr_i][b] <= wdata_i[b];
      end
    end
  end

  // Track written lanes; clear drops every lane back to all ones
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) vld_q[i] <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < Depth; i++) vld_q[i] <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= vld_q[waddr_i] | wmask_i;
    end
  end

  // Registered read, forward same-address written lanes
  always_ff @(posedge clk_i) begin
    if (rd_ok) begin
      rdata_q <= (wdata_i & fwd) | (mem_q[raddr_i] & ~fwd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= '0;
    end else if (clear_i) begin
      rvld_q <= '0;
    end else if (rd_ok) begin
      rvld_q <= vld_q[raddr_i] | fwd;
    end
  end

  assign rdata_o = rdata_q | ~rvld_q;

endmodule

### rtl/dscr_seq.sv
// Refresh sequencers for the long chain and the shared bar/button chains.
// Uses dscr_pkg; image bits arrive from dscr_ram the cycle after the address.
module dscr_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  logic               long_rd_i,
  input  logic [1:0]         shared_rd_i,
  output logic [6:0]         long_pos_o,
  output logic [6:0]         shared_pos_o,
  output dscr_pkg::out_t     res_o
);
  import dscr_pkg::*;

  typedef enum logic [7:0] {
    STEP_LATCH_LO  = 8'b0000_0001,
    STEP_LATCH_HI  = 8'b0000_0010,
    STEP_LATCH_END = 8'b0000_0100,
    STEP_SHIFT     = 8'b0000_1000,
    STEP_TAIL_LO   = 8'b0001_0000,
    STEP_TAIL_HI   = 8'b0010_0000,
    STEP_TAIL_END  = 8'b0100_0000,
    STEP_STOP      = 8'b1000_0000
  } step_e;

  typedef struct packed {
    step_e      step;
    logic [6:0] pos;
    logic       phase;
    logic       clk;
    logic       latch;
    logic [1:0] data;
  } chain_t;

  localparam logic [6:0] LongLast   = 7'(LongBits - 1);
  localparam logic [6:0] SharedLast = 7'(SharedBits - 1);

  // One step of a chain sequence
  function automatic chain_t advance(chain_t c, logic [6:0] last, logic [1:0] rd);
    chain_t r;
    r = c;
    case (c.step)
      STEP_LATCH_LO: begin
        r.latch = 1'b0;
        r.step  = STEP_LATCH_HI;
      end
      STEP_LATCH_HI: begin
        r.latch = 1'b1;
        r.step  = STEP_LATCH_END;
      end
      STEP_LATCH_END: begin
        r.latch = 1'b0;
        r.step  = STEP_SHIFT;
      end
      STEP_SHIFT: begin
        if (c.phase) begin
          r.phase = 1'b0;
          r.clk   = 1'b0;
          r.data  = rd;
        end else begin
          r.phase = 1'b1;
          r.clk   = 1'b1;
          if (c.pos >= last) r.step = STEP_TAIL_LO;
          r.pos = c.pos + 7'd1;
        end
      end
      STEP_TAIL_LO: begin
        r.latch = 1'b0;
        r.clk   = 1'b0;
        r.step  = STEP_TAIL_HI;
      end
      STEP_TAIL_HI: begin
        r.latch = 1'b1;
        r.step  = STEP_TAIL_END;
      end
      STEP_TAIL_END: begin
        r.latch = 1'b0;
        r.step  = STEP_STOP;
      end
      default: ;
    endcase
    return r;
  endfunction

  chain_t long_q, long_d, long_adv;
  chain_t shared_q, shared_d, shared_adv;
  logic   restart;

  // Advance both chains, restart together once both have stopped
  always_comb begin
    long_adv   = advance(long_q, LongLast, {1'b0, long_rd_i});
    shared_adv = advance(shared_q, SharedLast, shared_rd_i);
    restart    = (long_adv.step == STEP_STOP) && (shared_adv.step == STEP_STOP);
    if (restart) begin
      long_adv.step    = STEP_LATCH_LO;
      long_adv.pos     = 7'd0;
      long_adv.phase   = 1'b1;
      shared_adv.step  = STEP_LATCH_LO;
      shared_adv.pos   = 7'd0;
      shared_adv.phase = 1'b1;
    end
    long_d   = tick_i ? long_adv : long_q;
    shared_d = tick_i ? shared_adv : shared_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q   <= '{step: STEP_LATCH_LO, pos: 7'd0, phase: 1'b1,
                    clk: 1'b0, latch: 1'b0, data: 2'b00};
      shared_q <= '{step: STEP_LATCH_LO, pos: 7'd0, phase: 1'b1,
                    clk: 1'b0, latch: 1'b0, data: 2'b00};
    end else begin
      long_q   <= long_d;
      shared_q <= shared_d;
    end
  end

  // Prefetch the bit at the position the chain holds next cycle
  assign long_pos_o   = long_d.pos;
  assign shared_pos_o = shared_d.pos;

  assign res_o = '{long_clock:    long_d.clk,
                   long_data:     long_d.data[0],
                   long_latch:    long_d.latch,
                   shared_clock:  shared_d.clk,
                   bar_data:      shared_d.data[0],
                   button_data:   shared_d.data[1],
                   shared_latch:  shared_d.latch,
                   frame_restart: tick_i && restart};

endmodule

### rtl/dscr_out_fifo.sv
// Two-word result buffer between the sequencer and the output channel.
// Uses dscr_pkg for the result word type.
module dscr_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dscr_pkg::out_t push_word_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dscr_pkg::out_t out_word_o
);
  import dscr_pkg::*;

  out_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign full_o      = cnt_q[1];
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = slot_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Hold pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### rtl/dscr_checker.sv
// Port-level checker for the dual shift chain refresher, bound to the top.
// Uses dscr_pkg types and the assertion macros of the defines header.
`include "dual_shift_chain_refresher_defines.svh"

module dscr_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input dscr_pkg::out_t out_word_o
);
  import dscr_pkg::*;

  logic out_stall, in_acc, restart_shown, latches_low, clocks_low;
  assign out_stall     = out_valid_o && !out_ready_i;
  assign in_acc        = in_valid_i && in_ready_o;
  assign restart_shown = out_valid_o && out_word_o.frame_restart;
  assign latches_low   = !out_word_o.long_latch && !out_word_o.shared_latch;
  assign clocks_low    = !out_word_o.long_clock && !out_word_o.shared_clock;

  // A stalled result holds
  `DSCR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word_o))

  // Every accepted word produces a pending result next cycle
  `DSCR_ASSERT_NEXT(a_acc_out, clk_i, rst_ni, in_acc, out_valid_o)

  // A frame restart leaves both latches low
  `DSCR_ASSERT_NOW(a_restart_latch, clk_i, rst_ni, restart_shown, latches_low)

  // A frame restart leaves both shift clocks low
  `DSCR_ASSERT_NOW(a_restart_clock, clk_i, rst_ni, restart_shown, clocks_low)

  // An empty result buffer always takes input
  `DSCR_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

endmodule

bind dual_shift_chain_refresher dscr_checker u_dscr_checker (.*);

### tb/sv/tb_dual_shift_chain_refresher.sv
// Self-checking testbench for the dual shift chain refresher top level.
// Depends on dscr_pkg and the RTL; predicts every result word in-line and
// checks it against the output channel under random idling on both sides.
module tb_dual_shift_chain_refresher;
  import dscr_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomWords = 1100;
  localparam int ShowLimit   = 10;

  // func codes with no defined operation
  localparam logic [2:0] FuncSpareA = 3'd5;
  localparam logic [2:0] FuncSpareB = 3'd6;
  localparam logic [2:0] FuncSpareC = 3'd7;

  // per-chain sequencer steps
  typedef enum logic [2:0] {
    SEQ_OPEN_LO   = 3'd0,
    SEQ_OPEN_HI   = 3'd1,
    SEQ_OPEN_END  = 3'd2,
    SEQ_BITS      = 3'd3,
    SEQ_CLOSE_LO  = 3'd4,
    SEQ_CLOSE_HI  = 3'd5,
    SEQ_CLOSE_END = 3'd6,
    SEQ_STOPPED   = 3'd7
  } seq_e;

  typedef struct packed {
    seq_e       step;
    logic [6:0] pos;
    logic       phase;
    logic       running;
  } chain_t;

  localparam chain_t ChainStart = '{step: SEQ_OPEN_LO, pos: 7'd0, phase: 1'b1,
                                    running: 1'b1};

  logic  clk_i;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  out_ready_i = 1'b0;
  in_t   in_word_i   = '0;
  logic  in_ready_o;
  logic  out_valid_o;
  out_t  out_word_o;

  dual_shift_chain_refresher DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // predicted images, sequencers and pin levels
  logic [127:0] long_img;
  logic [127:0] bar_img;
  logic [127:0] button_img;
  chain_t       long_seq;
  chain_t       shared_seq;
  out_t         pin_state;

  out_t pending_pins[$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  bit   steady_flow    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Step one sequencer; load asks the caller to drive the data pins
  function automatic void advance_chain(inout chain_t c, inout logic clk,
                                        inout logic latch, input int unsigned length,
                                        output logic load);
    load = 1'b0;
    case (c.step)
      SEQ_OPEN_LO: begin
        latch  = 1'b0;
        c.step = SEQ_OPEN_HI;
      end
      SEQ_OPEN_HI: begin
        latch  = 1'b1;
        c.step = SEQ_OPEN_END;
      end
      SEQ_OPEN_END: begin
        latch  = 1'b0;
        c.step = SEQ_BITS;
      end
      SEQ_BITS: begin
        if (c.phase) begin
          c.phase = 1'b0;
          clk     = 1'b0;
          load    = 1'b1;
        end else begin
          c.phase = 1'b1;
          clk     = 1'b1;
          if (int'(c.pos) >= length - 1) c.step = SEQ_CLOSE_LO;
          c.pos = c.pos + 7'd1;
        end
      end
      SEQ_CLOSE_LO: begin
        latch  = 1'b0;
        clk    = 1'b0;
        c.step = SEQ_CLOSE_HI;
      end
      SEQ_CLOSE_HI: begin
        latch  = 1'b1;
        c.step = SEQ_CLOSE_END;
      end
      SEQ_CLOSE_END: begin
        latch     = 1'b0;
        c.running = 1'b0;
        c.step    = SEQ_STOPPED;
      end
      default: ;
    endcase
  endfunction

  // Apply one input word to the predicted state and return the result word
  function automatic out_t predict_pins(in_t w);
    logic load;
    out_t r;
    pin_state.frame_restart = 1'b0;
    case (w.func)
      FUNC_TICK: begin
        advance_chain(long_seq, pin_state.long_clock, pin_state.long_latch,
                      LongBits, load);
        if (load) pin_state.long_data = long_img[long_seq.pos];
        advance_chain(shared_seq, pin_state.shared_clock, pin_state.shared_latch,
                      SharedBits, load);
        if (load) begin
          pin_state.bar_data    = bar_img[shared_seq.pos];
          pin_state.button_data = button_img[shared_seq.pos];
        end
        if (!long_seq.running && !shared_seq.running) begin
          long_seq   = ChainStart;
          shared_seq = ChainStart;
          pin_state.frame_restart = 1'b1;
        end
      end
      FUNC_WR_LONG:   if (int'(w.pin_index) < LongBits) long_img[w.pin_index] = w.pin_level;
      FUNC_WR_BAR:    if (int'(w.pin_index) < SharedBits) bar_img[w.pin_index] = w.pin_level;
      FUNC_WR_BUTTON: begin
        if (int'(w.pin_index) < SharedBits) button_img[w.pin_index] = w.pin_level;
      end
      FUNC_ALL_OFF: begin
        long_img   = '1;
        bar_img    = '1;
        button_img = '1;
      end
      default: ;
    endcase
    r = pin_state;
    return r;
  endfunction

  // Send one word, idling at random first outside steady flow; hold valid until accepted
  task automatic push_word(in_t w);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pins.push_back(predict_pins(w));
  endtask

  task automatic push_fields(logic [2:0] func, int unsigned idx, logic lvl);
    in_t w;
    w.func      = func;
    w.pin_index = 7'(idx);
    w.pin_level = lvl;
    push_word(w);
  endtask

  // Edge indexes of each image, in range and past the end
  task automatic test_pin_writes();
    push_fields(FUNC_WR_LONG, 0, 1'b0);
    push_fields(FUNC_WR_LONG, LongBits - 1, 1'b0);
    push_fields(FUNC_WR_LONG, LongBits, 1'b0);
    push_fields(FUNC_WR_LONG, 127, 1'b0);
    push_fields(FUNC_WR_BAR, SharedBits - 1, 1'b0);
    push_fields(FUNC_WR_BAR, SharedBits, 1'b0);
    push_fields(FUNC_WR_BUTTON, 0, 1'b0);
    push_fields(FUNC_WR_BUTTON, 127, 1'b0);
  endtask

  task automatic test_spare_codes();
    push_fields(FuncSpareA, 0, 1'b1);
    push_fields(FuncSpareB, 127, 1'b0);
    push_fields(FuncSpareC, 64, 1'b1);
  endtask

  // Open latch pulse, first bit out, then all-off before the next bits
  task automatic test_ticks_and_all_off();
    repeat (5) push_fields(FUNC_TICK, 0, 1'b0);
    push_fields(FUNC_ALL_OFF, 0, 1'b0);
    repeat (4) push_fields(FUNC_TICK, 127, 1'b1);
  endtask

  // Mostly ticks so several full frames run, with writes mixed in
  task automatic test_random_traffic();
    in_t         w;
    int unsigned roll;
    for (int n = 0; n < RandomWords; n++) begin
      steady_flow = (n >= 300 && n < 500);
      roll        = $urandom_range(99);
      w.pin_index = 7'($urandom_range(127));
      w.pin_level = 1'($urandom_range(1));
      if (roll < 70)      w.func = FUNC_TICK;
      else if (roll < 78) w.func = FUNC_WR_LONG;
      else if (roll < 86) w.func = FUNC_WR_BAR;
      else if (roll < 94) w.func = FUNC_WR_BUTTON;
      else if (roll < 96) w.func = FUNC_ALL_OFF;
      else                w.func = 3'($urandom_range(FuncSpareC, FuncSpareA));
      push_word(w);
    end
    steady_flow = 1'b0;
  endtask

  // Stall the result channel at random outside steady flow
  always @(negedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= 31);
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    out_t exp_word;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pins.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ShowLimit)
          $display("unexpected result word %b at cycle %0d", out_word_o, cycle_count);
      end else begin
        exp_word = pending_pins.pop_front();
        if (out_word_o.long_clock    !== exp_word.long_clock   ||
            out_word_o.long_data     !== exp_word.long_data    ||
            out_word_o.long_latch    !== exp_word.long_latch   ||
            out_word_o.shared_clock  !== exp_word.shared_clock ||
            out_word_o.bar_data      !== exp_word.bar_data     ||
            out_word_o.button_data   !== exp_word.button_data  ||
            out_word_o.shared_latch  !== exp_word.shared_latch ||
            out_word_o.frame_restart !== exp_word.frame_restart) begin
          mismatch_count++;
          if (mismatch_count <= ShowLimit)
            $display({"mismatch at cycle %0d (lclk ldat llat sclk bar btn slat rst):",
                      " expected %b got %b"}, cycle_count, exp_word, out_word_o);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** dual_shift_chain_refresher: FAILED **");
      $finish;
    end
  end

  initial begin
    long_img   = '1;
    bar_img    = '1;
    button_img = '1;
    long_seq   = ChainStart;
    shared_seq = ChainStart;
    pin_state  = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pin_writes();
    test_spare_codes();
    test_ticks_and_all_off();
    test_random_traffic();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0 && pending_pins.size() == 0) begin
      $display("** dual_shift_chain_refresher: PASSED **");
    end else begin
      $display("** dual_shift_chain_refresher: FAILED **");
    end
    $finish;
  end

endmodule
